FILE: hw/rtl/mma_pkg.sv
// Shared constants, codes and control types for the 4x4 matrix multiply-accumulate.
// No dependencies; imported by mma_ctrl, mma_dp and matrix_4x4_multiply_accumulate.
`default_nettype none

package mma_pkg;

	localparam int MAT_DIM      = 4;
	localparam int FACTOR_WIDTH = 16;
	localparam int ACC_WIDTH    = 32;

	localparam int IDX_W     = (MAT_DIM > 1) ? $clog2(MAT_DIM) : 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int PROD_W    = 2 * FACTOR_WIDTH;
	// one guard bit above the wider of product and accumulator
	localparam int SUM_W     = ((PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH) + 1;

	localparam int FUNC_W = 2;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_C = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_START  = 2'd3;

	typedef logic [IDX_W-1:0]               idx_t;
	typedef logic signed [FACTOR_WIDTH-1:0] fac_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;

	localparam idx_t LAST_IDX = IDX_W'(MAT_DIM - 1);

	// controller -> datapath
	typedef struct packed {
		logic ld_en;   // load transfer: write A, B or C
		logic rd_en;   // issue one MAC step
		idx_t row;
		idx_t col;
		idx_t k;
		logic first;   // first step of an element: start from stored C
		logic last;    // final step of an element: write back and emit
		logic fin;     // element is the last of the run
	} mma_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic res_done;  // element result lands in the output register now
		logic out_free;  // output register empty or draining this cycle
	} mma_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mma_ctrl.sv
// Sequencer for the matrix multiply-accumulate: input handshake and MAC step issue.
// Depends on mma_pkg.
`default_nettype none

module mma_ctrl import mma_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [FUNC_W-1:0] func,
	input  wire mma_sts_t          sts,
	output      mma_cmd_t          cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;

	logic [1:0] state_q;
	idx_t       i_q, j_q, k_q;
	logic       fin_q;
	logic       in_xfer;
	logic       issue;
	logic       elem_last;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	// hold the first step until the previous result can leave the output register
	assign issue     = (state_q == S_ISSUE) && ((k_q != '0) || sts.out_free);
	assign elem_last = (i_q == LAST_IDX) && (j_q == LAST_IDX);

	always_comb begin
		cmd       = '0;
		cmd.ld_en = in_xfer && (func != FUNC_START);
		cmd.rd_en = issue;
		cmd.row   = i_q;
		cmd.col   = j_q;
		cmd.k     = k_q;
		cmd.first = (k_q == '0);
		cmd.last  = (k_q == LAST_IDX);
		cmd.fin   = elem_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			fin_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && (func == FUNC_START)) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (issue) begin
						if (k_q == LAST_IDX) begin
							k_q   <= '0;
							fin_q <= elem_last;
							if (j_q == LAST_IDX) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= S_WAIT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_WAIT: begin
					if (sts.res_done) begin
						state_q <= fin_q ? S_IDLE : S_ISSUE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result only completes while its element is draining
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.res_done |-> state_q == S_WAIT)
		else $error("result completed outside drain state");

	// no MAC step is issued while an input transfer is possible
	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !cmd.ld_en && in_stall)
		else $error("MAC issue overlaps input transfer");

endmodule

`default_nettype wire

FILE: hw/rtl/mma_dp.sv
// Datapath: A/B/C element stores, one pipelined saturating MAC, output register.
// Depends on mma_pkg; driven by mma_ctrl commands.
`default_nettype none

module mma_dp import mma_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mma_cmd_t          cmd,
	output      mma_sts_t          sts,
	input  wire logic [FUNC_W-1:0] func,
	input  wire idx_t              row_index,
	input  wire idx_t              col_index,
	input  wire fac_t              factor_value,
	input  wire acc_t              acc_value,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      idx_t              out_row,
	output      idx_t              out_col,
	output      acc_t              out_value,
	output      logic              last_of_run
);

	fac_t a_mem [MEM_DEPTH];
	fac_t b_mem [MEM_DEPTH];
	acc_t c_mem [MEM_DEPTH];

	logic              in_range;
	logic [ADDR_W-1:0] ld_addr;

	// stage 1: read data
	logic v_s1, first_s1, last_s1, fin_s1;
	idx_t row_s1, col_s1;
	fac_t a_s1, b_s1;
	acc_t c_s1;

	// stage 2: product
	logic v_s2, first_s2, last_s2, fin_s2;
	idx_t row_s2, col_s2;
	logic signed [PROD_W-1:0] prod_s2;
	acc_t c_s2;

	// accumulate
	acc_t                    acc_q;
	logic signed [SUM_W-1:0] base, sum;
	logic [SUM_W-ACC_WIDTH:0] top_bits;
	acc_t                    sat_val;
	logic                    res_done;
	logic                    out_valid_q;

	assign in_range = (int'(row_index) < MAT_DIM) && (int'(col_index) < MAT_DIM);
	assign ld_addr  = {row_index, col_index};

	// A and B: load port only
	always_ff @(posedge clk) begin
		if (cmd.ld_en && in_range && (func == FUNC_LOAD_A)) begin
			a_mem[ld_addr] <= factor_value;
		end
		if (cmd.ld_en && in_range && (func == FUNC_LOAD_B)) begin
			b_mem[ld_addr] <= factor_value;
		end
	end

	// C: load port or write-back; the two never coincide
	always_ff @(posedge clk) begin
		if (res_done) begin
			c_mem[{row_s2, col_s2}] <= sat_val;
		end else if (cmd.ld_en && in_range && (func == FUNC_LOAD_C)) begin
			c_mem[ld_addr] <= acc_value;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_mem[{cmd.row, cmd.k}];
		b_s1 <= b_mem[{cmd.k, cmd.col}];
		c_s1 <= c_mem[{cmd.row, cmd.col}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		fin_s1   <= cmd.fin;
		row_s1   <= cmd.row;
		col_s1   <= cmd.col;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		fin_s2   <= fin_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
		c_s2     <= c_s1;
		prod_s2  <= a_s1 * b_s1;
	end

	// saturating add: clamp when the bits above the sign disagree
	always_comb begin
		base     = first_s2 ? SUM_W'(c_s2) : SUM_W'(acc_q);
		sum      = base + SUM_W'(prod_s2);
		top_bits = sum[SUM_W-1:ACC_WIDTH-1];
		if ((top_bits == '0) || (top_bits == '1)) begin
			sat_val = sum[ACC_WIDTH-1:0];
		end else if (sum[SUM_W-1]) begin
			sat_val = {1'b1, {(ACC_WIDTH-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end
	end

	assign res_done = v_s2 && last_s2;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= sat_val;
		end
		if (res_done) begin
			out_row     <= row_s2;
			out_col     <= col_s2;
			out_value   <= sat_val;
			last_of_run <= fin_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.res_done = res_done;
	assign sts.out_free = !out_valid_q || !out_stall;

	// a new result never overwrites one still waiting downstream
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_done |-> (!out_valid_q || !out_stall))
		else $error("result overwrites stalled output");

	// the run's closing mark sits on the bottom-right element
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_of_run |-> (out_row == LAST_IDX) && (out_col == LAST_IDX))
		else $error("last_of_run on wrong element");

	// a MAC step reaching the adder was issued and has passed the read and product stages
	a_pipe_valid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(cmd.rd_en, 2))
		else $error("MAC pipeline valid without issue");

endmodule

`default_nettype wire

FILE: hw/rtl/matrix_4x4_multiply_accumulate.sv
// Top level of the 4x4 fixed-point matrix multiply-accumulate, C = C + A*B.
// Depends on mma_pkg, mma_ctrl and mma_dp.
//
// Input channel (in_valid / in_stall): one transfer per item. func selects
// load A, load B, load C or start. Loads write one element addressed by
// row_index / col_index; an index past the matrix size is dropped. A start
// runs the full product and blocks the input channel (in_stall high) until
// its last MAC step has been issued and the final result has landed.
// Output channel (out_valid / out_stall): sixteen transfers per start, in
// row-major order, last_of_run high on the final one. Values are Q16.16,
// saturated after each of the four partial-product additions.
// Datapath: one shared MAC unit, one product per cycle while an element's
// steps are issuing. An element needs four MAC steps, then the store-read
// and multiply stages, before its sum lands in the output register.
// A held output stalls only the first MAC step of the next element; one
// element is in flight at a time. Reset clears control and the output
// valid; the A, B and C stores hold garbage until loaded.
`default_nettype none

module matrix_4x4_multiply_accumulate import mma_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic [FUNC_W-1:0] func,
	input  wire idx_t              row_index,
	input  wire idx_t              col_index,
	input  wire fac_t              factor_value,
	input  wire acc_t              acc_value,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      idx_t              out_row,
	output      idx_t              out_col,
	output      acc_t              out_value,
	output      logic              last_of_run
);

	mma_cmd_t cmd;   // step/load commands from sequencer
	mma_sts_t sts;   // completion and output-space status

	mma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	mma_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.row_index    (row_index),
		.col_index    (col_index),
		.factor_value (factor_value),
		.acc_value    (acc_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire
